### hw/rtl/tbik_pkg.sv
// ----------------------------------------------------------------------------
// tbik_pkg: shared types, constants and helpers for the two-bone ik solver
// Fixed-point formats: points and lengths Q16.16, unit vectors Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

package tbik_pkg;

    // config register indexes
    localparam logic CFG_UPPER = 1'b0;
    localparam logic CFG_LOWER = 1'b1;

    // arithmetic constants
    localparam logic [30:0] LEN_FLOOR = 31'd7;
    localparam logic [30:0] MAX31     = 31'h7fffffff;
    localparam logic [31:0] UNIT_ONE  = 32'h40000000;
    localparam logic [31:0] Y_LIMIT   = 32'd966367642;

    // unit geometry
    localparam int SQ_STAGES  = 36;
    localparam int SQ_RAD_W   = 2 * SQ_STAGES;
    localparam int DIV_STAGES = 31;
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 34;

    // per-item context carried down the pipeline
    typedef struct packed {
        logic [2:0][31:0] root;
        logic [2:0][31:0] hint;
        logic [2:0]       dneg;
        logic [2:0][32:0] dmag;
        logic [2:0][65:0] dsq;
        logic [67:0]      dsum;
        logic [33:0]      dlen;
        logic             dzero;
        logic [31:0]      s;
        logic             reach;
        logic [30:0]      asked;
        logic [30:0]      used;
        logic [63:0]      ss;
        logic [63:0]      lim;
        logic [63:0]      diff;
        logic             adj_zero;
        logic             adj_full;
        logic [30:0]      adj;
        logic [2:0][31:0] dir;
        logic [61:0]      aa;
        logic [61:0]      h2;
        logic [2:0][63:0] dotp;
        logic [65:0]      dot;
        logic [33:0]      t;
        logic [2:0][65:0] tp;
        logic [2:0][34:0] bend;
        logic [2:0][31:0] fb;
        logic [2:0]       bneg;
        logic [2:0][33:0] bmag;
        logic [2:0]       fneg;
        logic [2:0][30:0] fmag;
        logic [2:0][67:0] bsq;
        logic [2:0][61:0] fsq;
        logic [69:0]      bsum;
        logic [63:0]      fsum;
        logic [30:0]      hgt;
        logic [33:0]      bl;
        logic             bzero;
        logic [2:0]       uneg;
        logic [2:0][33:0] umag;
        logic [2:0][31:0] bu;
        logic [2:0][65:0] ea;
        logic [2:0][65:0] eb;
        logic [2:0][65:0] eh;
        logic [2:0][37:0] ej;
        logic [2:0][37:0] ek;
    } ctx_t;

    // divide by 2^30, round to nearest, ties away from zero
    function automatic logic signed [35:0] rq30(input logic signed [65:0] v);
        logic [65:0] m;
        logic [65:0] r;
        m = v[65] ? 66'(-v) : 66'(v);
        r = (m + 66'd536870912) >> 30;
        rq30 = v[65] ? $signed(36'd0 - r[35:0]) : $signed(r[35:0]);
    endfunction

    // saturate to signed 32 bits
    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        logic [31:0] r;
        if (v > 38'sd2147483647)
            r = 32'h7fffffff;
        else if (v < -38'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        sat32 = r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tbik_sqrt.sv
// ----------------------------------------------------------------------------
// tbik_sqrt: pipelined integer square root
// One result bit per stage, restoring method, floor of the root.
// ----------------------------------------------------------------------------
`default_nettype none

module tbik_sqrt
(
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [tbik_pkg::SQ_RAD_W-1:0]  rad,
    output logic      [tbik_pkg::SQ_STAGES-1:0] root
);

    logic [tbik_pkg::SQ_RAD_W-1:0]  rem_reg [tbik_pkg::SQ_STAGES];
    logic [tbik_pkg::SQ_STAGES-1:0] res_reg [tbik_pkg::SQ_STAGES];

    for (genvar j = 0; j < tbik_pkg::SQ_STAGES; j++) begin : g_stage
        logic [tbik_pkg::SQ_RAD_W-1:0]  rem_in;
        logic [tbik_pkg::SQ_RAD_W-1:0]  trial;
        logic [tbik_pkg::SQ_STAGES-1:0] res_in;

        if (j == 0) begin : g_first
            assign rem_in = rad;
            assign res_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        assign trial = (tbik_pkg::SQ_RAD_W'(res_in) << (tbik_pkg::SQ_STAGES - j))
                     | (tbik_pkg::SQ_RAD_W'(1) << (2 * (tbik_pkg::SQ_STAGES - 1 - j)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[j] <= rem_in - trial;
                    res_reg[j] <= res_in
                                | (tbik_pkg::SQ_STAGES'(1) << (tbik_pkg::SQ_STAGES - 1 - j));
                end
                else
                begin
                    rem_reg[j] <= rem_in;
                    res_reg[j] <= res_in;
                end
            end
        end
    end

    assign root = res_reg[tbik_pkg::SQ_STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/tbik_div.sv
// ----------------------------------------------------------------------------
// tbik_div: pipelined unsigned divider
// One quotient bit per stage; quotient assumed below 2^31.
// ----------------------------------------------------------------------------
`default_nettype none

module tbik_div
(
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [tbik_pkg::DIV_NUM_W-1:0]  num,
    input  wire logic [tbik_pkg::DIV_DEN_W-1:0]  den,
    output logic      [tbik_pkg::DIV_STAGES-1:0] quo
);

    logic [tbik_pkg::DIV_NUM_W-1:0]  rem_reg [tbik_pkg::DIV_STAGES];
    logic [tbik_pkg::DIV_DEN_W-1:0]  den_reg [tbik_pkg::DIV_STAGES];
    logic [tbik_pkg::DIV_STAGES-1:0] quo_reg [tbik_pkg::DIV_STAGES];

    for (genvar j = 0; j < tbik_pkg::DIV_STAGES; j++) begin : g_stage
        logic [tbik_pkg::DIV_NUM_W-1:0]  rem_in;
        logic [tbik_pkg::DIV_DEN_W-1:0]  den_in;
        logic [tbik_pkg::DIV_STAGES-1:0] quo_in;
        logic [tbik_pkg::DIV_NUM_W:0]    trial;

        if (j == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        // shifted divisor for this quotient bit
        assign trial = (tbik_pkg::DIV_NUM_W+1)'(den_in) << (tbik_pkg::DIV_STAGES - 1 - j);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j] <= den_in;
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_reg[j] <= rem_in - trial[tbik_pkg::DIV_NUM_W-1:0];
                    quo_reg[j] <= quo_in
                                | (tbik_pkg::DIV_STAGES'(1) << (tbik_pkg::DIV_STAGES - 1 - j));
                end
                else
                begin
                    rem_reg[j] <= rem_in;
                    quo_reg[j] <= quo_in;
                end
            end
        end
    end

    assign quo = quo_reg[tbik_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/two_bone_ik_solver_unit.sv
// ----------------------------------------------------------------------------
// two_bone_ik_solver_unit: pipelined two-bone inverse kinematics solver
// Places elbow and hand from shoulder, target and pole hint, Q16.16.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one pose query per transaction: tdata holds root, goal and
//   hint points, x/y/z each, 32 bits per field, lowest first.
//   m_axis returns one result per query in the same order: tdata holds
//   joint, end, asked_distance, used_distance; tuser holds in_reach.
//   cfg_we/cfg_index/cfg_data write the upper and lower arm lengths; write
//   only while no query is in flight.
// throughput and structure
//   one query per cycle while the output is not stalled; the pipeline contains
//   two 36-stage square root sections and two 31-stage divider sections,
//   one result bit per stage.
// reset and stall
//   rst_n clears all valid bits and loads both lengths with 1.0.
//   when the output register holds a result that is not taken, the whole
//   pipeline holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module two_bone_ik_solver_unit
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // root_x, root_y, root_z, goal_x, goal_y, goal_z, hint_x, hint_y, hint_z
    input  wire logic [287:0] s_axis_tdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // joint_x, joint_y, joint_z, end_x, end_y, end_z, asked_distance,
    // used_distance, two zero bits
    output logic      [255:0] m_axis_tdata,
    // in_reach
    output logic      [0:0]   m_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [30:0]  cfg_data
);

    localparam int SQ = tbik_pkg::SQ_STAGES;
    localparam int DV = tbik_pkg::DIV_STAGES;

    logic adv;

    // config registers and derived constants
    logic [30:0] upper_reg;
    logic [30:0] lower_reg;
    logic [30:0] up_reg;
    logic [30:0] lo_reg;
    logic [31:0] minr_reg;
    logic [31:0] maxr_reg;
    logic [61:0] upup_reg;
    logic [61:0] lolo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= 31'd65536;
            lower_reg <= 31'd65536;
            up_reg    <= 31'd65536;
            lo_reg    <= 31'd65536;
            minr_reg  <= 32'd1;
            maxr_reg  <= 32'd131072;
            upup_reg  <= 62'd4294967296;
            lolo_reg  <= 62'd4294967296;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tbik_pkg::CFG_UPPER: upper_reg <= cfg_data;
                    tbik_pkg::CFG_LOWER: lower_reg <= cfg_data;
                endcase
            end
            up_reg   <= (upper_reg < tbik_pkg::LEN_FLOOR) ? tbik_pkg::LEN_FLOOR : upper_reg;
            lo_reg   <= (lower_reg < tbik_pkg::LEN_FLOOR) ? tbik_pkg::LEN_FLOOR : lower_reg;
            minr_reg <= ((up_reg > lo_reg) ? 32'(up_reg - lo_reg) : 32'(lo_reg - up_reg))
                      + 32'd1;
            maxr_reg <= 32'(up_reg) + 32'(lo_reg);
            upup_reg <= 62'(up_reg) * 62'(up_reg);
            lolo_reg <= 62'(lo_reg) * 62'(lo_reg);
        end
    end

    // pipeline registers
    tbik_pkg::ctx_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p7_reg, p8_reg;
    tbik_pkg::ctx_t p9_reg, p10_reg, p11_reg, p12_reg, p13_reg, p14_reg, p15_reg;
    tbik_pkg::ctx_t p16_reg, p17_reg, p18_reg, p19_reg;
    tbik_pkg::ctx_t p1_next, p2_next, p3_next, p4_next, p5_next, p6_next, p7_next;
    tbik_pkg::ctx_t p8_next, p9_next, p10_next, p11_next, p12_next, p13_next;
    tbik_pkg::ctx_t p14_next, p15_next, p16_next, p17_next, p18_next, p19_next;
    tbik_pkg::ctx_t qa_reg [SQ];
    tbik_pkg::ctx_t qb_reg [DV];
    tbik_pkg::ctx_t qc_reg [SQ];
    tbik_pkg::ctx_t qd_reg [DV];

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic v10_reg, v11_reg, v12_reg, v13_reg, v14_reg, v15_reg, v16_reg, v17_reg;
    logic v18_reg, v19_reg;
    logic [SQ-1:0] va_reg;
    logic [DV-1:0] vb_reg;
    logic [SQ-1:0] vc_reg;
    logic [DV-1:0] vd_reg;

    logic [255:0] out_data_reg;
    logic         out_reach_reg;
    logic         out_valid_reg;

    // unit results
    logic [SQ-1:0]      sq_dist;
    logic [SQ-1:0]      sq_bend;
    logic [SQ-1:0]      sq_fall;
    logic [SQ-1:0]      sq_hgt;
    logic [2:0][DV-1:0] q_dir;
    logic [DV-1:0]      q_adj;
    logic [2:0][DV-1:0] q_bu;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // offset from shoulder to target
    always_comb
    begin
        logic signed [32:0] dd;
        p1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            p1_next.root[i] = s_axis_tdata[i*32 +: 32];
            p1_next.hint[i] = s_axis_tdata[(6+i)*32 +: 32];
            dd = 33'($signed(s_axis_tdata[(3+i)*32 +: 32]))
               - 33'($signed(s_axis_tdata[i*32 +: 32]));
            p1_next.dneg[i] = dd[32];
            p1_next.dmag[i] = dd[32] ? 33'(-dd) : 33'(dd);
        end
    end

    // squares of the offset
    always_comb
    begin
        p2_next = p1_reg;
        for (int i = 0; i < 3; i++)
            p2_next.dsq[i] = 66'(p1_reg.dmag[i]) * 66'(p1_reg.dmag[i]);
    end

    // sum of squares
    always_comb
    begin
        p3_next = p2_reg;
        p3_next.dsum = 68'(p2_reg.dsq[0]) + 68'(p2_reg.dsq[1]) + 68'(p2_reg.dsq[2]);
    end

    tbik_sqrt u_sqrt_dist
    (
        .clk  (clk),
        .en   (adv),
        .rad  ({4'b0, p3_reg.dsum}),
        .root (sq_dist)
    );

    // reach clamp and limit flags
    always_comb
    begin
        logic [33:0] dl;
        p4_next = qa_reg[SQ-1];
        dl      = sq_dist[33:0];
        p4_next.dlen  = dl;
        p4_next.dzero = (dl == 34'd0);
        if (dl < 34'(minr_reg))
            p4_next.s = minr_reg;
        else if (dl > 34'(maxr_reg))
            p4_next.s = maxr_reg;
        else
            p4_next.s = dl[31:0];
        p4_next.reach = (35'(dl) + 35'd1 >= 35'(minr_reg))
                     && (35'(dl) <= 35'(maxr_reg) + 35'd1);
        p4_next.asked = (dl > 34'(tbik_pkg::MAX31)) ? tbik_pkg::MAX31 : dl[30:0];
        p4_next.used  = (p4_next.s > 32'(tbik_pkg::MAX31)) ? tbik_pkg::MAX31
                                                           : p4_next.s[30:0];
    end

    // law of cosines products
    always_comb
    begin
        p5_next = p4_reg;
        p5_next.ss  = 64'(p4_reg.s) * 64'(p4_reg.s);
        p5_next.lim = 64'({p4_reg.s, 1'b0}) * 64'(up_reg);
    end

    // numerator and adjacent side limits
    always_comb
    begin
        logic [64:0] num;
        logic [64:0] dfull;
        p6_next = p5_reg;
        num   = 65'(upup_reg) + 65'(p5_reg.ss);
        dfull = num - 65'(lolo_reg);
        p6_next.adj_zero = (num <= 65'(lolo_reg));
        p6_next.diff     = dfull[63:0];
        p6_next.adj_full = (65'(p5_reg.lim) <= dfull);
    end

    for (genvar i = 0; i < 3; i++) begin : g_div_dir
        tbik_div u_div
        (
            .clk (clk),
            .en  (adv),
            .num ({1'b0, p6_reg.dmag[i], 30'b0}),
            .den (p6_reg.dlen),
            .quo (q_dir[i])
        );
    end

    tbik_div u_div_adj
    (
        .clk (clk),
        .en  (adv),
        .num (p6_reg.diff),
        .den ({1'b0, p6_reg.s, 1'b0}),
        .quo (q_adj)
    );

    // aim direction and adjacent side
    always_comb
    begin
        p7_next = qb_reg[DV-1];
        for (int i = 0; i < 3; i++)
        begin
            if (qb_reg[DV-1].dzero)
                p7_next.dir[i] = (i == 2) ? tbik_pkg::UNIT_ONE : 32'd0;
            else if (qb_reg[DV-1].dneg[i])
                p7_next.dir[i] = 32'd0 - 32'(q_dir[i]);
            else
                p7_next.dir[i] = 32'(q_dir[i]);
        end
        priority if (qb_reg[DV-1].adj_zero)
            p7_next.adj = 31'd0;
        else if (qb_reg[DV-1].adj_full)
            p7_next.adj = up_reg;
        else
            p7_next.adj = q_adj;
    end

    // hint projection products and fallback bend vector
    always_comb
    begin
        logic [31:0] ady;
        p8_next = p7_reg;
        p8_next.aa = 62'(p7_reg.adj) * 62'(p7_reg.adj);
        for (int i = 0; i < 3; i++)
            p8_next.dotp[i] = 64'($signed(p7_reg.hint[i])) * 64'($signed(p7_reg.dir[i]));
        ady = p7_reg.dir[1][31] ? 32'd0 - p7_reg.dir[1] : p7_reg.dir[1];
        if (ady < tbik_pkg::Y_LIMIT)
        begin
            p8_next.fb[0] = 32'd0 - p7_reg.dir[2];
            p8_next.fb[1] = 32'd0;
            p8_next.fb[2] = p7_reg.dir[0];
        end
        else
        begin
            p8_next.fb[0] = 32'd0;
            p8_next.fb[1] = p7_reg.dir[2];
            p8_next.fb[2] = 32'd0 - p7_reg.dir[1];
        end
    end

    // height radicand and dot product sum
    always_comb
    begin
        p9_next = p8_reg;
        p9_next.h2  = upup_reg - p8_reg.aa;
        p9_next.dot = 66'($signed(p8_reg.dotp[0])) + 66'($signed(p8_reg.dotp[1]))
                    + 66'($signed(p8_reg.dotp[2]));
    end

    // projection length
    always_comb
    begin
        logic signed [35:0] r;
        p10_next = p9_reg;
        r = tbik_pkg::rq30($signed(p9_reg.dot));
        p10_next.t = r[33:0];
    end

    // projection onto aim
    always_comb
    begin
        p11_next = p10_reg;
        for (int i = 0; i < 3; i++)
            p11_next.tp[i] = 66'($signed(p10_reg.t)) * 66'($signed(p10_reg.dir[i]));
    end

    // perpendicular part of the hint
    always_comb
    begin
        logic signed [35:0] r;
        p12_next = p11_reg;
        for (int i = 0; i < 3; i++)
        begin
            r = tbik_pkg::rq30($signed(p11_reg.tp[i]));
            p12_next.bend[i] = 35'($signed(p11_reg.hint[i])) - r[34:0];
        end
    end

    // magnitudes of bend and fallback
    always_comb
    begin
        logic [34:0] b;
        logic [31:0] f;
        p13_next = p12_reg;
        for (int i = 0; i < 3; i++)
        begin
            b = p12_reg.bend[i];
            f = p12_reg.fb[i];
            p13_next.bneg[i] = b[34];
            p13_next.bmag[i] = b[34] ? 34'(35'd0 - b) : b[33:0];
            p13_next.fneg[i] = f[31];
            p13_next.fmag[i] = f[31] ? 31'(32'd0 - f) : f[30:0];
        end
    end

    // squares of bend and fallback
    always_comb
    begin
        p14_next = p13_reg;
        for (int i = 0; i < 3; i++)
        begin
            p14_next.bsq[i] = 68'(p13_reg.bmag[i]) * 68'(p13_reg.bmag[i]);
            p14_next.fsq[i] = 62'(p13_reg.fmag[i]) * 62'(p13_reg.fmag[i]);
        end
    end

    // sums of squares
    always_comb
    begin
        p15_next = p14_reg;
        p15_next.bsum = 70'(p14_reg.bsq[0]) + 70'(p14_reg.bsq[1]) + 70'(p14_reg.bsq[2]);
        p15_next.fsum = 64'(p14_reg.fsq[0]) + 64'(p14_reg.fsq[1]) + 64'(p14_reg.fsq[2]);
    end

    tbik_sqrt u_sqrt_bend
    (
        .clk  (clk),
        .en   (adv),
        .rad  ({2'b0, p15_reg.bsum}),
        .root (sq_bend)
    );

    tbik_sqrt u_sqrt_fall
    (
        .clk  (clk),
        .en   (adv),
        .rad  ({8'b0, p15_reg.fsum}),
        .root (sq_fall)
    );

    tbik_sqrt u_sqrt_hgt
    (
        .clk  (clk),
        .en   (adv),
        .rad  ({10'b0, p15_reg.h2}),
        .root (sq_hgt)
    );

    // choose bend or fallback vector
    always_comb
    begin
        p16_next = qc_reg[SQ-1];
        p16_next.hgt = sq_hgt[30:0];
        if (sq_bend[33:0] != 34'd0)
        begin
            p16_next.uneg = qc_reg[SQ-1].bneg;
            p16_next.umag = qc_reg[SQ-1].bmag;
            p16_next.bl   = sq_bend[33:0];
        end
        else
        begin
            p16_next.uneg = qc_reg[SQ-1].fneg;
            for (int i = 0; i < 3; i++)
                p16_next.umag[i] = 34'(qc_reg[SQ-1].fmag[i]);
            p16_next.bl = sq_fall[33:0];
        end
        p16_next.bzero = (p16_next.bl == 34'd0);
    end

    for (genvar i = 0; i < 3; i++) begin : g_div_bu
        tbik_div u_div
        (
            .clk (clk),
            .en  (adv),
            .num ({p16_reg.umag[i], 30'b0}),
            .den (p16_reg.bl),
            .quo (q_bu[i])
        );
    end

    // bend unit vector
    always_comb
    begin
        p17_next = qd_reg[DV-1];
        for (int i = 0; i < 3; i++)
        begin
            if (qd_reg[DV-1].bzero)
                p17_next.bu[i] = (i == 2) ? tbik_pkg::UNIT_ONE : 32'd0;
            else if (qd_reg[DV-1].uneg[i])
                p17_next.bu[i] = 32'd0 - 32'(q_bu[i]);
            else
                p17_next.bu[i] = 32'(q_bu[i]);
        end
    end

    // placement products
    always_comb
    begin
        p18_next = p17_reg;
        for (int i = 0; i < 3; i++)
        begin
            p18_next.ea[i] = 66'($signed(p17_reg.dir[i])) * 66'($signed({1'b0, p17_reg.adj}));
            p18_next.eb[i] = 66'($signed(p17_reg.bu[i])) * 66'($signed({1'b0, p17_reg.hgt}));
            p18_next.eh[i] = 66'($signed(p17_reg.dir[i])) * 66'($signed({1'b0, p17_reg.s}));
        end
    end

    // elbow and hand points
    always_comb
    begin
        p19_next = p18_reg;
        for (int i = 0; i < 3; i++)
        begin
            p19_next.ej[i] = 38'($signed(p18_reg.root[i]))
                           + 38'(tbik_pkg::rq30($signed(p18_reg.ea[i])))
                           + 38'(tbik_pkg::rq30($signed(p18_reg.eb[i])));
            p19_next.ek[i] = 38'($signed(p18_reg.root[i]))
                           + 38'(tbik_pkg::rq30($signed(p18_reg.eh[i])));
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            p4_reg  <= p4_next;
            p5_reg  <= p5_next;
            p6_reg  <= p6_next;
            p7_reg  <= p7_next;
            p8_reg  <= p8_next;
            p9_reg  <= p9_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
            p12_reg <= p12_next;
            p13_reg <= p13_next;
            p14_reg <= p14_next;
            p15_reg <= p15_next;
            p16_reg <= p16_next;
            p17_reg <= p17_next;
            p18_reg <= p18_next;
            p19_reg <= p19_next;
            qa_reg[0] <= p3_reg;
            qb_reg[0] <= p6_reg;
            qc_reg[0] <= p15_reg;
            qd_reg[0] <= p16_reg;
            for (int i = 1; i < SQ; i++)
            begin
                qa_reg[i] <= qa_reg[i-1];
                qc_reg[i] <= qc_reg[i-1];
            end
            for (int i = 1; i < DV; i++)
            begin
                qb_reg[i] <= qb_reg[i-1];
                qd_reg[i] <= qd_reg[i-1];
            end
        end
    end

    // output payload with saturation
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {2'b0, p19_reg.used, p19_reg.asked,
                             tbik_pkg::sat32($signed(p19_reg.ek[2])),
                             tbik_pkg::sat32($signed(p19_reg.ek[1])),
                             tbik_pkg::sat32($signed(p19_reg.ek[0])),
                             tbik_pkg::sat32($signed(p19_reg.ej[2])),
                             tbik_pkg::sat32($signed(p19_reg.ej[1])),
                             tbik_pkg::sat32($signed(p19_reg.ej[0]))};
            out_reach_reg <= p19_reg.reach;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
            v14_reg <= 1'b0;
            v15_reg <= 1'b0;
            v16_reg <= 1'b0;
            v17_reg <= 1'b0;
            v18_reg <= 1'b0;
            v19_reg <= 1'b0;
            va_reg  <= '0;
            vb_reg  <= '0;
            vc_reg  <= '0;
            vd_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= s_axis_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            va_reg  <= {va_reg[SQ-2:0], v3_reg};
            v4_reg  <= va_reg[SQ-1];
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            vb_reg  <= {vb_reg[DV-2:0], v6_reg};
            v7_reg  <= vb_reg[DV-1];
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
            v14_reg <= v13_reg;
            v15_reg <= v14_reg;
            vc_reg  <= {vc_reg[SQ-2:0], v15_reg};
            v16_reg <= vc_reg[SQ-1];
            vd_reg  <= {vd_reg[DV-2:0], v16_reg};
            v17_reg <= vd_reg[DV-1];
            v18_reg <= v17_reg;
            v19_reg <= v18_reg;
            out_valid_reg <= v19_reg;
        end
    end

    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_reach_reg;
    assign m_axis_tvalid = out_valid_reg;

    // a stalled result blocks new transactions
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // adjacent side never exceeds the upper arm
    a_adj_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg |-> (p7_reg.adj <= up_reg))
        else $error("adjacent side above upper length");

    // bend unit vector is never zero
    a_bu_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v17_reg |-> (p17_reg.bu != '0))
        else $error("zero bend direction");

    // clamped reach stays within the arm sum
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[253:223]) <= maxr_reg))
        else $error("used distance beyond arm sum");

endmodule

`default_nettype wire
